[hw/rtl/assert_macros.svh]
// assertion macros for the rtl files, included by gostcfb_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define GC_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define GC_ASSERT(label, clk, rst_n, prop)
`define GC_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[hw/rtl/gostcfb_pkg.sv]
// types, constants and round helpers for the gost cfb cipher with mac
package gostcfb_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY01   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY23   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY45   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY67   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IV      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 3'd5;

  localparam logic [63:0] KEY01_RST = 64'h0000_0002_0000_0001;
  localparam logic [63:0] KEY23_RST = 64'h0000_0004_0000_0003;
  localparam logic [63:0] KEY45_RST = 64'h0000_0006_0000_0005;
  localparam logic [63:0] KEY67_RST = 64'h0000_0008_0000_0007;
  localparam logic [63:0] IV_RST    = 64'h0807_0605_0403_0201;

  localparam int ROT_L = 11;

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd4, 4'd10, 4'd9, 4'd2, 4'd13, 4'd8, 4'd0, 4'd14,
      4'd6, 4'd11, 4'd1, 4'd12, 4'd7, 4'd15, 4'd5, 4'd3},
    '{4'd14, 4'd11, 4'd4, 4'd12, 4'd6, 4'd13, 4'd15, 4'd10,
      4'd2, 4'd3, 4'd8, 4'd1, 4'd0, 4'd7, 4'd5, 4'd9},
    '{4'd5, 4'd8, 4'd1, 4'd13, 4'd10, 4'd3, 4'd4, 4'd2,
      4'd14, 4'd15, 4'd12, 4'd7, 4'd6, 4'd0, 4'd9, 4'd11},
    '{4'd7, 4'd13, 4'd10, 4'd1, 4'd0, 4'd8, 4'd9, 4'd15,
      4'd14, 4'd4, 4'd6, 4'd12, 4'd11, 4'd2, 4'd5, 4'd3},
    '{4'd6, 4'd12, 4'd7, 4'd1, 4'd5, 4'd15, 4'd13, 4'd8,
      4'd4, 4'd10, 4'd9, 4'd14, 4'd0, 4'd3, 4'd11, 4'd2},
    '{4'd4, 4'd11, 4'd10, 4'd0, 4'd7, 4'd2, 4'd1, 4'd13,
      4'd3, 4'd6, 4'd8, 4'd5, 4'd9, 4'd12, 4'd15, 4'd14},
    '{4'd13, 4'd11, 4'd4, 4'd1, 4'd3, 4'd15, 4'd5, 4'd9,
      4'd0, 4'd10, 4'd14, 4'd7, 4'd6, 4'd8, 4'd2, 4'd12},
    '{4'd1, 4'd15, 4'd13, 4'd0, 4'd5, 4'd7, 4'd10, 4'd4,
      4'd9, 4'd2, 4'd3, 4'd14, 4'd6, 4'd11, 4'd8, 4'd12}
  };

  typedef logic [7:0][31:0] key_sched_t;

  typedef struct packed {
    key_sched_t  keys;
    logic [63:0] iv;
    logic        decrypt;
  } cfg_t;

  typedef struct packed {
    logic [63:0] data_block;
    logic [3:0]  valid_bytes;
    logic        last_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_block;
    logic [3:0]  result_bytes;
    logic [31:0] mac_tag;
    logic        last;
  } out_item_t;

  function automatic logic [31:0] sbox_sub(input logic [31:0] s);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 4] = SBOX[i][s[4*i +: 4]];
    end
    return r;
  endfunction

  function automatic logic [31:0] rotl11(input logic [31:0] x);
    return {x[31-ROT_L:0], x[31:32-ROT_L]};
  endfunction

  // counts above eight saturate
  function automatic logic [3:0] clip_count(input logic [3:0] c);
    return (c > 4'd8) ? 4'd8 : c;
  endfunction

  function automatic logic [63:0] byte_mask(input logic [3:0] c);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < c) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

[hw/rtl/gost_cfb_cipher_with_mac.sv]
// top level: configuration registers, cipher core and result register
// Each accepted 64-bit block runs 32 keystream rounds and then 16 MAC rounds through one shared
// GOST round unit, one round per clock; the result is written to the output register as the core
// leaves its finishing state, and only then, with the core idle again, can the next block be
// accepted. in_stall is high for the whole of that work and also while a finished
// result waits for a full output register to drain. Configuration writes are always taken
// (cfg_ready is tied high) and are meant to be made only while the block is idle.
module gost_cfb_cipher_with_mac
  import gostcfb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [63:0] key01_r, key23_r, key45_r, key67_r, iv_r;
  logic        dec_r;
  cfg_t        cfg;
  logic        res_valid, res_taken, out_free;
  out_item_t   res_data;
  logic        out_valid_r;
  out_item_t   out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r <= KEY01_RST;
      key23_r <= KEY23_RST;
      key45_r <= KEY45_RST;
      key67_r <= KEY67_RST;
      iv_r    <= IV_RST;
      dec_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY01:   key01_r <= cfg_data;
        CFG_KEY23:   key23_r <= cfg_data;
        CFG_KEY45:   key45_r <= cfg_data;
        CFG_KEY67:   key67_r <= cfg_data;
        CFG_IV:      iv_r    <= cfg_data;
        CFG_DECRYPT: dec_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.keys    = {key67_r, key45_r, key23_r, key01_r};
    cfg.iv      = iv_r;
    cfg.decrypt = dec_r;
  end

  gostcfb_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_taken (res_taken),
    .res_data  (res_data)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign res_taken = res_valid && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_taken) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/gostcfb_round.sv]
// one gost round: key add, s-box substitution, rotate and xor
module gostcfb_round
  import gostcfb_pkg::*;
(
  input  logic [31:0] n1,
  input  logic [31:0] n2,
  input  logic [31:0] key,
  output logic [31:0] t
);

  logic [31:0] sum;

  assign sum = 32'(n1 + key);
  assign t   = n2 ^ rotl11(sbox_sub(sum));

endmodule

[hw/rtl/gostcfb_core.sv]
// round sequencer, feedback and mac state around the shared round unit
`include "assert_macros.svh"
module gostcfb_core
  import gostcfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      res_valid,
  input  logic      res_taken,
  output out_item_t res_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CIPH = 4'b0010,
    ST_MAC  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [4:0]  rnd_r, rnd_nxt;
  logic [31:0] n1_r, n1_nxt, n2_r, n2_nxt;
  logic [63:0] data_r, data_nxt, mask_r, mask_nxt;
  logic [3:0]  count_r, count_nxt;
  logic        last_r, last_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] fb_r, fb_nxt, mac_r, mac_nxt;
  logic [31:0] tag_r, tag_nxt;

  logic [2:0]  kidx;
  logic [31:0] t;
  logic [63:0] gamma, res_c, plain, mac_in;
  logic [3:0]  cnt_c;
  logic [63:0] msk_c;

  // keys 0..7 three times, then 7..0; mac uses 0..7 twice
  always_comb begin
    if (state_r == ST_CIPH && rnd_r[4] && rnd_r[3]) begin
      kidx = ~rnd_r[2:0];
    end else begin
      kidx = rnd_r[2:0];
    end
  end

  gostcfb_round u_round (
    .n1  (n1_r),
    .n2  (n2_r),
    .key (cfg.keys[kidx]),
    .t   (t)
  );

  assign cnt_c  = clip_count(in_data.valid_bytes);
  assign msk_c  = byte_mask(cnt_c);
  assign gamma  = {t, n1_r};
  assign res_c  = (data_r ^ gamma) & mask_r;
  assign plain  = cfg.decrypt ? res_c : data_r;
  assign mac_in = mac_r ^ plain;

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    n1_nxt    = n1_r;
    n2_nxt    = n2_r;
    data_nxt  = data_r;
    mask_nxt  = mask_r;
    count_nxt = count_r;
    last_nxt  = last_r;
    res_nxt   = res_r;
    fb_nxt    = fb_r;
    mac_nxt   = mac_r;
    tag_nxt   = tag_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          data_nxt  = in_data.data_block & msk_c;
          mask_nxt  = msk_c;
          count_nxt = cnt_c;
          last_nxt  = in_data.last_block;
          n1_nxt    = fb_r[31:0];
          n2_nxt    = fb_r[63:32];
          rnd_nxt   = '0;
          state_nxt = ST_CIPH;
        end
      end
      ST_CIPH: begin
        if (&rnd_r) begin
          // final round: gamma keeps n1 unswapped; store result block, update feedback, load mac state
          res_nxt   = res_c;
          fb_nxt    = last_r ? cfg.iv : (cfg.decrypt ? data_r : res_c);
          n1_nxt    = mac_in[31:0];
          n2_nxt    = mac_in[63:32];
          rnd_nxt   = '0;
          state_nxt = ST_MAC;
        end else begin
          n1_nxt  = t;
          n2_nxt  = n1_r;
          rnd_nxt = 5'(rnd_r + 5'd1);
        end
      end
      ST_MAC: begin
        n1_nxt = t;
        n2_nxt = n1_r;
        if (rnd_r == 5'd15) begin
          tag_nxt   = last_r ? t : '0;
          mac_nxt   = last_r ? '0 : {n1_r, t};
          state_nxt = ST_FIN;
        end else begin
          rnd_nxt = 5'(rnd_r + 5'd1);
        end
      end
      ST_FIN: begin
        if (res_taken) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      fb_r    <= IV_RST;
      mac_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      fb_r    <= fb_nxt;
      mac_r   <= mac_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n1_r    <= n1_nxt;
    n2_r    <= n2_nxt;
    data_r  <= data_nxt;
    mask_r  <= mask_nxt;
    count_r <= count_nxt;
    last_r  <= last_nxt;
    res_r   <= res_nxt;
    tag_r   <= tag_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_FIN);

  always_comb begin
    res_data.result_block = res_r;
    res_data.result_bytes = count_r;
    res_data.mac_tag      = tag_r;
    res_data.last         = last_r;
  end

  `GC_ASSERT_NEVER(a_mac_rnd_bound, clk, rst_n, (state_r == ST_MAC) && rnd_r[4])
  `GC_ASSERT(a_ciph_to_mac, clk, rst_n, (state_r == ST_CIPH) && (&rnd_r) |=> (state_r == ST_MAC) && (rnd_r == 5'd0))
  `GC_ASSERT(a_fin_release, clk, rst_n, (state_r == ST_FIN) && res_taken |=> (state_r == ST_IDLE))

endmodule
